### src/pirl_pkg.sv
// ----------------------------------------------------------------------------
// pirl_pkg
// Shared types and constants for the positional insert/remove list core.
// ----------------------------------------------------------------------------
package pirl_pkg;

    // number of cells in the chain, the list holds at most DEPTH-1 entries
    localparam int DEPTH    = 128;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int ENTRY_W  = 7;
    localparam int STATUS_W = 2;

    // count and cell index width, count never exceeds DEPTH-1
    localparam int CNT_W = $clog2(DEPTH);
    // width wide enough to compare a position against DEPTH and the count
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic             ins_en;
        logic             rem_en;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] limit;
    } ctrl_t;

endpackage

### src/pirl_cell.sv
// ----------------------------------------------------------------------------
// pirl_cell
// One list entry: loads the new word, its left neighbor or its right
// neighbor depending on the broadcast shift command.
// ----------------------------------------------------------------------------
module pirl_cell (
    input  logic                          aclk,
    input  pirl_pkg::ctrl_t               ctrl,
    input  logic [pirl_pkg::CNT_W-1:0]    idx,
    input  logic [pirl_pkg::DATA_W-1:0]   word,
    input  logic [pirl_pkg::DATA_W-1:0]   left_data,
    input  logic [pirl_pkg::DATA_W-1:0]   right_data,
    output logic [pirl_pkg::DATA_W-1:0]   data_out
);

    logic [pirl_pkg::DATA_W-1:0] data_reg;
    logic [pirl_pkg::DATA_W-1:0] data_next;

    // insert: cell at pos loads word, cells above it up to limit shift up
    // remove: cells from pos below limit take the right neighbor
    always_comb begin
        data_next = data_reg;
        if (ctrl.ins_en) begin
            if (idx == ctrl.pos) begin
                data_next = word;
            end else if ((idx > ctrl.pos) && (idx <= ctrl.limit)) begin
                data_next = left_data;
            end
        end else if (ctrl.rem_en) begin
            if ((idx >= ctrl.pos) && (idx < ctrl.limit)) begin
                data_next = right_data;
            end
        end
    end

    // entry storage, undefined until written
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

### src/positional_insert_remove_list_core.sv
// ----------------------------------------------------------------------------
// positional_insert_remove_list_core
// Ordered list of signed words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid/s_ready) carries one request per transaction:
//   s_req_type 0 inserts s_item_value at s_position, 1 removes the entry at
//   s_position. Positions past the count append (inserts below DEPTH) or remove the last entry.
//   The result channel (m_valid/m_ready) returns one transaction per request
//   with a status code, the entry count and the front entry after the step.
//   The result is registered on the edge that accepts the request.
//   Throughput is one request per cycle while the receiver takes results;
//   every cell of the chain shifts in parallel on that same edge, so the
//   cell compare and load mux set the cycle time.
//   The list counts as full at DEPTH-1 entries; a refused request leaves the
//   list unchanged and reports its reason in m_status.
//   When the receiver stalls, the pending result holds in the output
//   register and s_ready drops until it is taken.
//   Reset (aresetn low, synchronous) empties the list and drops m_valid;
//   cell contents are not cleared; the reported front is zero while the list is empty.
// ----------------------------------------------------------------------------
module positional_insert_remove_list_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [pirl_pkg::POS_W-1:0]        s_position,
    input  logic signed [pirl_pkg::DATA_W-1:0] s_item_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pirl_pkg::STATUS_W-1:0]     m_status,
    output logic [pirl_pkg::ENTRY_W-1:0]      m_entry_count,
    output logic signed [pirl_pkg::DATA_W-1:0] m_front_value
);

    logic [pirl_pkg::CNT_W-1:0]  count_reg;
    logic [pirl_pkg::CNT_W-1:0]  count_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    pirl_pkg::status_t           status_reg;
    pirl_pkg::status_t           status_next;
    logic [pirl_pkg::DATA_W-1:0] front_reg;
    logic [pirl_pkg::DATA_W-1:0] front_next;
    logic [pirl_pkg::CNT_W-1:0]  entry_cnt_reg;

    logic                        accept;
    logic [pirl_pkg::CMP_W-1:0]  pos_ext;
    logic [pirl_pkg::CMP_W-1:0]  count_ext;
    logic [pirl_pkg::CNT_W-1:0]  last_idx;
    logic [pirl_pkg::CNT_W-1:0]  ins_pos;
    logic [pirl_pkg::CNT_W-1:0]  rem_pos;
    pirl_pkg::ctrl_t             ctrl;

    logic [pirl_pkg::DATA_W-1:0] cell_data [pirl_pkg::DEPTH];

    // output register frees the input side once taken
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // effective positions clamped to the count
    assign pos_ext   = pirl_pkg::CMP_W'(s_position);
    assign count_ext = pirl_pkg::CMP_W'(count_reg);
    assign last_idx  = count_reg - pirl_pkg::CNT_W'(1);
    assign ins_pos   = (pos_ext < count_ext) ? pirl_pkg::CNT_W'(pos_ext) : count_reg;
    assign rem_pos   = (pos_ext < pirl_pkg::CMP_W'(last_idx)) ?
                       pirl_pkg::CNT_W'(pos_ext) : last_idx;

    // request decode, status, count and front entry after the step
    always_comb begin
        ctrl        = '0;
        status_next = pirl_pkg::ST_DONE;
        count_next  = count_reg;
        front_next  = cell_data[0];
        if (!s_req_type) begin
            if (count_reg >= pirl_pkg::CNT_W'(pirl_pkg::DEPTH - 1)) begin
                status_next = pirl_pkg::ST_FULL;
            end else if (pos_ext >= pirl_pkg::CMP_W'(pirl_pkg::DEPTH)) begin
                status_next = pirl_pkg::ST_BADPOS;
            end else begin
                ctrl.ins_en = accept;
                ctrl.pos    = ins_pos;
                ctrl.limit  = count_reg;
                count_next  = count_reg + pirl_pkg::CNT_W'(1);
                if (ins_pos == '0) begin
                    front_next = s_item_value;
                end
            end
        end else begin
            if (count_reg == '0) begin
                status_next = pirl_pkg::ST_EMPTY;
            end else begin
                ctrl.rem_en = accept;
                ctrl.pos    = rem_pos;
                ctrl.limit  = last_idx;
                count_next  = last_idx;
                if (rem_pos == '0) begin
                    front_next = cell_data[1];
                end
            end
        end
        if (count_next == '0) begin
            front_next = '0;
        end
    end

    // chain of entry cells
    for (genvar gi = 0; gi < pirl_pkg::DEPTH; gi++) begin : g_cell
        logic [pirl_pkg::DATA_W-1:0] left_d;
        logic [pirl_pkg::DATA_W-1:0] right_d;
        if (gi == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[gi-1];
        end
        if (gi == pirl_pkg::DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[gi+1];
        end
        pirl_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .idx        (pirl_pkg::CNT_W'(gi)),
            .word       (s_item_value),
            .left_data  (left_d),
            .right_data (right_d),
            .data_out   (cell_data[gi])
        );
    end

    // valid flag of the output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= status_next;
            entry_cnt_reg <= count_next;
            front_reg     <= front_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_entry_count = pirl_pkg::ENTRY_W'(entry_cnt_reg);
    assign m_front_value = front_reg;

`ifndef SYNTHESIS
    // list never grows past DEPTH-1 entries
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pirl_pkg::CNT_W'(pirl_pkg::DEPTH - 1))
        else $error("entry count above capacity");

    // every accepted transaction produces a result
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("no result after accepted transaction");

    // a completed insert grows the list by one
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_req_type && (status_next == pirl_pkg::ST_DONE))
        |=> (count_reg == $past(count_reg) + pirl_pkg::CNT_W'(1)))
        else $error("insert did not grow the list");

    // empty status always reports an empty list with a zero front
    a_empty_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (status_reg == pirl_pkg::ST_EMPTY))
        |-> ((entry_cnt_reg == '0) && (front_reg == '0)))
        else $error("empty status with nonempty result");
`endif

endmodule

### bench/pirl_tb_pkg.sv
// ----------------------------------------------------------------------------
// pirl_tb_pkg
// Request codes and the result record shared by the list testbench files.
// ----------------------------------------------------------------------------
package pirl_tb_pkg;

    import pirl_pkg::*;

    // request kinds carried on s_req_type
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_kind_t;

    // one result transaction as the list should report it
    typedef struct packed {
        status_t                   status;
        logic [ENTRY_W-1:0]        count;
        logic signed [DATA_W-1:0]  front;
    } list_result_t;

endpackage

### bench/pirl_list_checker.sv
// ----------------------------------------------------------------------------
// pirl_list_checker
// Watches both channels of the list core, keeps a shadow copy of the list,
// predicts every result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module pirl_list_checker
    import pirl_pkg::*;
    import pirl_tb_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [POS_W-1:0]          s_position,
    input  logic signed [DATA_W-1:0]  s_item_value,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [STATUS_W-1:0]       m_status,
    input  logic [ENTRY_W-1:0]        m_entry_count,
    input  logic signed [DATA_W-1:0]  m_front_value,
    output int                        error_count,
    output int                        results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the stored words and their number
    logic signed [DATA_W-1:0] shadow_list [DEPTH];
    int                       shadow_count;
    list_result_t             expected_results [$];

    task automatic flag_error(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    // apply one request to the shadow list and build the result it causes
    function automatic list_result_t apply_request(input req_kind_t kind,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] word);
        list_result_t res;
        int           slot;
        res.status = ST_DONE;
        if (kind == REQ_INSERT) begin
            if (shadow_count >= DEPTH - 1) begin
                res.status = ST_FULL;
            end else if (int'(pos) >= DEPTH) begin
                res.status = ST_BADPOS;
            end else begin
                // positions past the end append
                slot = (int'(pos) < shadow_count) ? int'(pos) : shadow_count;
                for (int i = shadow_count; i > slot; i--) begin
                    shadow_list[i] = shadow_list[i-1];
                end
                shadow_list[slot] = word;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                // positions past the end take the last entry
                slot = (int'(pos) < shadow_count - 1) ? int'(pos) : shadow_count - 1;
                for (int i = slot; i < shadow_count - 1; i++) begin
                    shadow_list[i] = shadow_list[i+1];
                end
                shadow_count--;
            end
        end
        res.count = ENTRY_W'(shadow_count);
        res.front = (shadow_count != 0) ? shadow_list[0] : '0;
        return res;
    endfunction

    // compare results first, then queue the prediction for a new request
    always @(posedge aclk) begin : watch
        list_result_t want;
        if (!aresetn) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("result with nothing pending: status %0d count %0d front %0d",
                                         m_status, m_entry_count, m_front_value));
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        flag_error($sformatf("status %0d, expected %s",
                                             m_status, want.status.name()));
                    if (m_entry_count !== want.count)
                        flag_error($sformatf("entry_count %0d, expected %0d",
                                             m_entry_count, want.count));
                    if (m_front_value !== want.front)
                        flag_error($sformatf("front_value %0d, expected %0d",
                                             m_front_value, want.front));
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_request(req_kind_t'(s_req_type),
                                                         s_position, s_item_value));
            end
        end
        results_pending = expected_results.size();
    end

endmodule

### bench/positional_insert_remove_list_core_tb.sv
// ----------------------------------------------------------------------------
// positional_insert_remove_list_core_tb
// Drives inserts and removes into the list core: a directed pass over the
// edge cases, then fill, drain and mixed runs with random positions and words
// under changing sender gaps and receiver stalls, and one long receiver stall.
// ----------------------------------------------------------------------------
module positional_insert_remove_list_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pirl_pkg::*;
    import pirl_tb_pkg::*;

    localparam int RUN_ITEMS   = 1250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AT     = 450;

    logic                      aclk;
    logic                      aresetn      = 1'b0;
    logic                      s_valid      = 1'b0;
    logic                      s_ready;
    logic                      s_req_type   = 1'b0;
    logic [POS_W-1:0]          s_position   = '0;
    logic signed [DATA_W-1:0]  s_item_value = '0;
    logic                      m_valid;
    logic                      m_ready      = 1'b0;
    logic [STATUS_W-1:0]       m_status;
    logic [ENTRY_W-1:0]        m_entry_count;
    logic signed [DATA_W-1:0]  m_front_value;

    int   error_count;
    int   results_pending;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    logic hold_req           = 1'b0;
    // entries the list should hold once every offered request is taken
    int   list_level         = 0;
    int   items_sent         = 0;

    positional_insert_remove_list_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_position    (s_position),
        .s_item_value  (s_item_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .m_front_value (m_front_value)
    );

    pirl_list_checker list_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_position      (s_position),
        .s_item_value    (s_item_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_entry_count   (m_entry_count),
        .m_front_value   (m_front_value),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver side: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        bit hold_served;
        hold_left   = 0;
        hold_served = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_served) begin
                hold_served = 1;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("positional_insert_remove_list_core_tb: errors");
        $finish;
    end

    // offer one request and return at the edge that takes it
    task automatic push_request(input req_kind_t kind, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] word);
        bit taken;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= kind;
        s_position   <= pos;
        s_item_value <= word;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        if (kind == REQ_INSERT) begin
            if (list_level < DEPTH - 1 && int'(pos) < DEPTH) list_level++;
        end else if (list_level > 0) begin
            list_level--;
        end
        items_sent++;
    endtask

    // idling mode rotates every hundred transactions
    task automatic update_pace();
        case ((items_sent / 100) % 4)
            0: begin
                sender_idle_pct    <= 0;
                receiver_stall_pct <= 0;
            end
            1: begin
                sender_idle_pct    <= 47;
                receiver_stall_pct <= 0;
            end
            2: begin
                sender_idle_pct    <= 0;
                receiver_stall_pct <= 47;
            end
            default: begin
                sender_idle_pct    <= 34;
                receiver_stall_pct <= 34;
            end
        endcase
        if (items_sent == HOLD_AT) hold_req <= 1'b1;
    endtask

    // mostly inside the list, some anywhere, some at the boundaries
    function automatic logic [POS_W-1:0] pick_position();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return POS_W'($urandom_range(list_level));
        if (roll < 85) return POS_W'($urandom_range((1 << POS_W) - 1));
        case ($urandom_range(4))
            0:       return '0;
            1:       return POS_W'(list_level);
            2:       return POS_W'(DEPTH - 1);
            3:       return POS_W'(DEPTH);
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_word();
        if ($urandom_range(99) < 80) return $urandom;
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic offer(input req_kind_t kind, input logic [POS_W-1:0] pos);
        update_pace();
        push_request(kind, pos, pick_word());
    endtask

    task automatic offer_random(input int insert_pct);
        offer(($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE, pick_position());
    endtask

    initial begin : stimulus
        int seg;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty list, bad positions, append, front and middle moves
        push_request(REQ_REMOVE, 8'd0, 32'sd0);
        push_request(REQ_REMOVE, 8'd255, 32'sd0);
        push_request(REQ_INSERT, POS_W'(DEPTH), 32'sd5);
        push_request(REQ_INSERT, 8'd255, 32'sd6);
        push_request(REQ_INSERT, 8'd0, 32'h7FFF_FFFF);
        push_request(REQ_INSERT, POS_W'(DEPTH - 1), 32'h8000_0000);
        push_request(REQ_INSERT, 8'd0, 32'hFFFF_FFFF);
        push_request(REQ_INSERT, 8'd1, 32'h0000_0000);
        push_request(REQ_INSERT, 8'd3, 32'h1234_5678);
        push_request(REQ_INSERT, 8'd200, 32'sd1);
        push_request(REQ_REMOVE, 8'd255, 32'sd0);
        push_request(REQ_REMOVE, 8'd1, 32'sd0);
        push_request(REQ_REMOVE, 8'd0, 32'sd0);
        push_request(REQ_REMOVE, 8'd4, 32'sd0);
        push_request(REQ_REMOVE, 8'd0, 32'sd0);
        push_request(REQ_REMOVE, 8'd0, 32'sd0);
        push_request(REQ_INSERT, 8'd0, 32'hA5A5_A5A5);
        push_request(REQ_REMOVE, 8'd0, 32'sd0);

        // random: fill to full, mix, drain to empty, mix
        seg = 0;
        while (items_sent < RUN_ITEMS) begin
            case (seg % 4)
                0: begin
                    while (list_level < DEPTH - 1) offer_random(90);
                    // full list, also with a bad position
                    offer(REQ_INSERT, POS_W'(DEPTH));
                    offer(REQ_INSERT, 8'd255);
                    offer(REQ_INSERT, pick_position());
                end
                2: begin
                    while (list_level > 0) offer_random(15);
                    offer(REQ_REMOVE, pick_position());
                    offer(REQ_REMOVE, 8'd255);
                end
                default: begin
                    repeat (60) offer_random(50);
                end
            endcase
            seg++;
        end
        s_valid <= 1'b0;

        do @(negedge aclk); while (results_pending != 0);
        repeat (4) @(posedge aclk);
        if (error_count == 0) begin
            $display("positional_insert_remove_list_core_tb: clean");
        end else begin
            $display("positional_insert_remove_list_core_tb: errors");
        end
        $finish;
    end

endmodule
